// File: rtl/xkc_pkg.sv
package xkc_pkg;

	// key and word geometry
	localparam int MAX_KEY_CHARS = 16;
	localparam int CHAR_W        = 8;
	localparam int WORD_W        = 32;
	localparam int PROD_W        = 2 * WORD_W;
	localparam int KEY_HALF_W    = 64;
	localparam int KEY_BITS      = 2 * KEY_HALF_W;
	localparam int LEN_W         = 5;
	localparam int CHAR_IDX_W    = 4;
	localparam int CFG_IDX_W     = 2;

	// keystream modulus and its scaled reciprocal, floor(2^32 / modulus)
	// the quotient estimate is low by at most one, so one subtract corrects it
	localparam logic [WORD_W-1:0] MODULUS = 32'h0000_beef;
	localparam logic [WORD_W-1:0] RECIP   = 32'd87869;
	localparam int REM_W = 17;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

	// raw key character at position p, zero past the key storage
	function automatic logic [CHAR_W-1:0] key_byte(input logic [KEY_BITS-1:0] keys,
			input logic [LEN_W-1:0] p);
		logic [CHAR_W-1:0] b;
		b = keys[{p[CHAR_IDX_W-1:0], 3'b000} +: CHAR_W];
		if (p[LEN_W-1]) begin
			b = '0;
		end
		return b;
	endfunction

endpackage

// File: rtl/xkc_if.sv
interface xkc_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       message_start;

	modport source (output valid, output data_byte, output message_start, input ready);
	modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface xkc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;

	modport source (output valid, output result_byte, input ready);
	modport sink   (input valid, input result_byte, output ready);
endinterface

interface xkc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/xkc_mul.sv
module xkc_mul (
	input  logic                        clk,
	input  logic [xkc_pkg::WORD_W-1:0]  op_a,
	input  logic [xkc_pkg::WORD_W-1:0]  op_b,
	output logic [xkc_pkg::PROD_W-1:0]  prod_q
);

	// unsigned 32x32 multiply, full product registered
	always_ff @(posedge clk) begin
		prod_q <= xkc_pkg::PROD_W'(op_a) * xkc_pkg::PROD_W'(op_b);
	end

endmodule

// File: rtl/xor_keystream_cipher.sv
// channel   dir  handshake      payload
// cfg       in   valid/ready    index[1:0], data[63:0] (always ready)
// req       in   valid/ready    data_byte[7:0], message_start
// rsp       out  valid/ready    result_byte[7:0]
//
// one shared registered 32x32 multiplier under a state sequencer does all multiplies
// a byte steps from accept through wrap, mix, magnitude, reciprocal estimate,
// back-multiply and correction, then returns to idle before the next accept
// a byte with message_start first runs derivation through DPROD, DSUMP, DSPICE, DNEXT
// per effective key character (three multiplies per character on the same multiplier)
// arst_n clears counters, derived values and keys; rsp stalls hold the result
// register and stop the sequencer only when a new result must be loaded
module xor_keystream_cipher (
	input  logic        clk,
	input  logic        arst_n,
	xkc_cfg_if.sink     cfg,
	xkc_req_if.sink     req,
	xkc_rsp_if.source   rsp
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DPROD  = 4'd1;
	localparam logic [3:0] ST_DSUMP  = 4'd2;
	localparam logic [3:0] ST_DSPICE = 4'd3;
	localparam logic [3:0] ST_DNEXT  = 4'd4;
	localparam logic [3:0] ST_WRAP   = 4'd5;
	localparam logic [3:0] ST_MIX    = 4'd6;
	localparam logic [3:0] ST_ABS    = 4'd7;
	localparam logic [3:0] ST_QEST   = 4'd8;
	localparam logic [3:0] ST_QMUL   = 4'd9;
	localparam logic [3:0] ST_RSUB   = 4'd10;

	localparam int W = xkc_pkg::WORD_W;
	localparam int LW = xkc_pkg::LEN_W;
	localparam int CW = xkc_pkg::CHAR_W;

	logic [3:0]                     state_q;
	logic [3:0]                     state_next;
	logic [xkc_pkg::KEY_HALF_W-1:0] key_low_q;
	logic [xkc_pkg::KEY_HALF_W-1:0] key_high_q;
	logic [LW-1:0]                  key_len_q;
	logic [LW-1:0]                  len_q;
	logic [LW-1:0]                  p_q;
	logic [LW-1:0]                  pos_q;
	logic [W-1:0]                   idx_q;
	logic [W-1:0]                   wrap_q;
	logic [W-1:0]                   sum_q;
	logic [W-1:0]                   prod_q;
	logic [W-1:0]                   spice_q;
	logic [W-1:0]                   mag_q;
	logic [W-1:0]                   quot_q;
	logic                           neg_q;
	logic [CW-1:0]                  data_q;
	logic                           out_valid_q;
	logic [CW-1:0]                  out_byte_q;

	logic [xkc_pkg::KEY_BITS-1:0]   keys;
	logic [LW-1:0]                  lim;
	logic [LW-1:0]                  eff_len;
	logic [W-1:0]                   mul_a;
	logic [W-1:0]                   mul_b;
	logic [xkc_pkg::PROD_W-1:0]     mul_p;
	logic [W-1:0]                   mul_lo;
	logic [CW-1:0]                  c_raw;
	logic [CW-1:0]                  c_prev_raw;
	logic [W-1:0]                   c_ext;
	logic [W-1:0]                   fac_ext;
	logic                           pos_wrap;
	logic [W-1:0]                   wrap_next;
	logic [W-1:0]                   mix;
	logic [W-1:0]                   r_full;
	logic [xkc_pkg::REM_W-1:0]      r_est;
	logic [xkc_pkg::REM_W-1:0]      rem;
	logic [CW-1:0]                  rem_s8;
	logic [CW-1:0]                  kc8;
	logic                           req_take;
	logic                           out_load;

	assign keys   = {key_high_q, key_low_q};
	assign mul_lo = mul_p[W-1:0];

	// configuration writes, always accepted
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				xkc_pkg::REG_KEY_LOW:  key_low_q  <= cfg.data;
				xkc_pkg::REG_KEY_HIGH: key_high_q <= cfg.data;
				xkc_pkg::REG_KEY_LEN:  key_len_q  <= cfg.data[LW-1:0];
				default: ;
			endcase
		end
	end

	// effective key length: saturate, then cut at the first zero character
	always_comb begin
		lim = (key_len_q > LW'(xkc_pkg::MAX_KEY_CHARS)) ?
			LW'(xkc_pkg::MAX_KEY_CHARS) : key_len_q;
		eff_len = lim;
		for (int p = xkc_pkg::MAX_KEY_CHARS - 1; p >= 0; p--) begin
			if (LW'(p) < lim && xkc_pkg::key_byte(keys, LW'(p)) == '0) begin
				eff_len = LW'(p);
			end
		end
	end

	// key characters used by derivation and by the keystream
	always_comb begin
		c_raw      = (p_q < len_q) ? xkc_pkg::key_byte(keys, p_q) : '0;
		c_prev_raw = xkc_pkg::key_byte(keys, p_q - LW'(1));
		c_ext      = {{(W-CW){c_raw[CW-1]}}, c_raw};
		fac_ext    = (c_raw != '0) ? c_ext : {{(W-CW){c_prev_raw[CW-1]}}, c_prev_raw};
		kc8        = (pos_q < len_q) ? xkc_pkg::key_byte(keys, pos_q) : '0;
	end

	// position wrap and mixed word
	assign pos_wrap  = (pos_q >= len_q);
	assign wrap_next = pos_wrap ? wrap_q + W'(1) : wrap_q;
	assign mix       = W'(len_q) ^ idx_q ^ mul_lo ^ prod_q;

	// remainder correction from reciprocal estimate
	always_comb begin
		r_full = mag_q - mul_lo;
		r_est  = r_full[xkc_pkg::REM_W-1:0];
		rem    = (r_est >= xkc_pkg::REM_W'(xkc_pkg::MODULUS)) ?
			r_est - xkc_pkg::REM_W'(xkc_pkg::MODULUS) : r_est;
		rem_s8 = neg_q ? CW'(-rem[CW-1:0]) : rem[CW-1:0];
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DPROD: begin
				mul_a = prod_q;
				mul_b = fac_ext;
			end
			ST_DSUMP: begin
				mul_a = sum_q;
				mul_b = mul_lo;
			end
			ST_DSPICE: begin
				mul_a = spice_q;
				mul_b = mul_lo;
			end
			ST_WRAP: begin
				mul_a = wrap_next;
				mul_b = sum_q;
			end
			ST_MIX: begin
				mul_a = spice_q;
				mul_b = mix;
			end
			ST_QEST: begin
				mul_a = mag_q;
				mul_b = xkc_pkg::RECIP;
			end
			ST_QMUL: begin
				mul_a = mul_p[xkc_pkg::PROD_W-1:W];
				mul_b = xkc_pkg::MODULUS;
			end
			// keep the back-multiply product steady while the result waits
			ST_RSUB: begin
				mul_a = quot_q;
				mul_b = xkc_pkg::MODULUS;
			end
			default: ;
		endcase
	end

	xkc_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (mul_p)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_take  = req.valid && req.ready;
	assign out_load  = (state_q == ST_RSUB) && (!out_valid_q || rsp.ready);

	// sequencer next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					state_next = (req.message_start && eff_len != '0) ? ST_DPROD : ST_WRAP;
				end
			end
			ST_DPROD:  state_next = ST_DSUMP;
			ST_DSUMP:  state_next = ST_DSPICE;
			ST_DSPICE: state_next = ST_DNEXT;
			ST_DNEXT:  state_next = (p_q == len_q) ? ST_WRAP : ST_DPROD;
			ST_WRAP:   state_next = ST_MIX;
			ST_MIX:    state_next = ST_ABS;
			ST_ABS:    state_next = ST_QEST;
			ST_QEST:   state_next = ST_QMUL;
			ST_QMUL:   state_next = ST_RSUB;
			ST_RSUB:   state_next = out_load ? ST_IDLE : ST_RSUB;
			default:   state_next = ST_IDLE;
		endcase
	end

	// sequencer state and cipher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			p_q     <= '0;
			pos_q   <= '0;
			idx_q   <= '0;
			wrap_q  <= '0;
			sum_q   <= '0;
			prod_q  <= W'(1);
			spice_q <= W'(1);
		end else begin
			state_q <= state_next;
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						len_q <= eff_len;
						if (req.message_start) begin
							p_q     <= LW'(1);
							pos_q   <= '0;
							idx_q   <= '0;
							wrap_q  <= '0;
							sum_q   <= '0;
							prod_q  <= W'(1);
							spice_q <= W'(1);
						end
					end
				end
				ST_DPROD: sum_q <= sum_q + c_ext;
				ST_DSUMP: prod_q <= mul_lo;
				ST_DNEXT: begin
					spice_q <= mul_lo;
					p_q     <= p_q + LW'(1);
				end
				ST_WRAP: begin
					wrap_q <= wrap_next;
					if (pos_wrap) begin
						pos_q <= '0;
					end
				end
				ST_RSUB: begin
					if (out_load) begin
						pos_q <= pos_q + LW'(1);
						idx_q <= idx_q + W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// item payload, keystream magnitude and quotient estimate
	always_ff @(posedge clk) begin
		if (req_take) begin
			data_q <= req.data_byte;
		end
		if (state_q == ST_ABS) begin
			neg_q <= mul_lo[W-1];
			mag_q <= mul_lo[W-1] ? -mul_lo : mul_lo;
		end
		if (state_q == ST_QMUL) begin
			quot_q <= mul_p[xkc_pkg::PROD_W-1:W];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= data_q ^ (kc8 + rem_s8);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_byte = out_byte_q;

	// an accepted item always starts the sequencer
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> state_q != ST_IDLE)
		else $error("sequencer did not start on accepted item");

	// leaving the correction step always leaves a result waiting
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RSUB && state_next == ST_IDLE) |=> out_valid_q)
		else $error("result not loaded at end of item");

	// derivation position stays inside the key
	a_deriv_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DPROD || state_q == ST_DNEXT) |-> (p_q != '0 && p_q <= len_q))
		else $error("derivation position out of range");

	// corrected remainder is below the modulus
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RSUB |-> rem < xkc_pkg::REM_W'(xkc_pkg::MODULUS))
		else $error("remainder estimate off by more than one");

	// latched length never exceeds the key storage
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> len_q <= LW'(xkc_pkg::MAX_KEY_CHARS))
		else $error("effective key length out of range");

endmodule
